### design/cleb_pkg.sv
// Shared types, constants and register codes for the cursor line edit buffer.
`default_nettype none

package cleb_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int CHAR_W       = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_HOME   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELETE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 3'd4;

    localparam logic [CHAR_W-1:0] HOME_RST   = 8'd91;
    localparam logic [CHAR_W-1:0] END_RST    = 8'd93;
    localparam logic [CHAR_W-1:0] DELETE_RST = 8'd45;
    localparam logic [CHAR_W-1:0] RIGHT_RST  = 8'd62;
    localparam logic [CHAR_W-1:0] LEFT_RST   = 8'd60;

    typedef enum logic [2:0] {
        K_HOME,
        K_END,
        K_DEL,
        K_RIGHT,
        K_LEFT,
        K_INS
    } t_key_op;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_HOME,
        DP_END,
        DP_OVF,
        DP_RD_CUR,
        DP_RIGHT,
        DP_LEFT,
        DP_DEL_WR,
        DP_INS_W1,
        DP_INS_W2,
        DP_RO_START,
        DP_RO_STEP,
        DP_RO_EMPTY
    } t_dp_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_APPLY,
        ST_INS_W2,
        ST_RO_WALK
    } t_state;

    typedef struct packed {
        t_key_op key_op;
        logic    is_readout;
        logic    cur_at_head;
        logic    cur_at_tail;
        logic    full;
        logic    list_empty;
        logic    out_free;
        logic    walk_last;
    } t_dp_status;

endpackage

`default_nettype wire

### design/cleb_in_if.sv
// Input channel: command and keystroke byte with valid/ready.
`default_nettype none

interface cleb_in_if;
    logic                     valid;
    logic                     ready;
    logic                     command;
    logic [cleb_pkg::CHAR_W-1:0] key;

    modport source (output valid, output command, output key, input ready);
    modport sink   (input valid, input command, input key, output ready);
endinterface

`default_nettype wire

### design/cleb_out_if.sv
// Output channel: one text character per transaction with valid/ready.
`default_nettype none

interface cleb_out_if;
    logic                     valid;
    logic                     ready;
    logic [cleb_pkg::CHAR_W-1:0] char_out;
    logic                     has_char;
    logic                     overflowed;
    logic                     last;

    modport source (output valid, output char_out, output has_char, output overflowed,
                    output last, input ready);
    modport sink   (input valid, input char_out, input has_char, input overflowed,
                    input last, output ready);
endinterface

`default_nettype wire

### design/cleb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cleb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/cleb_ctrl.sv
// Controller state machine: sequences keystroke and readout operations.
`default_nettype none

module cleb_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output      logic                 o_in_ready,
    input  wire cleb_pkg::t_dp_status i_status,
    output      cleb_pkg::t_dp_op     o_op
);

    cleb_pkg::t_state r_state;
    cleb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cleb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_op       = cleb_pkg::DP_NOP;
        o_in_ready = 1'b0;
        case (r_state)
            cleb_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op    = cleb_pkg::DP_CAPTURE;
                    n_state = cleb_pkg::ST_DISPATCH;
                end
            end
            cleb_pkg::ST_DISPATCH: begin
                n_state = cleb_pkg::ST_IDLE;
                if (i_status.is_readout) begin
                    if (!i_status.list_empty) begin
                        o_op    = cleb_pkg::DP_RO_START;
                        n_state = cleb_pkg::ST_RO_WALK;
                    end else if (i_status.out_free) begin
                        o_op = cleb_pkg::DP_RO_EMPTY;
                    end else begin
                        n_state = cleb_pkg::ST_DISPATCH;
                    end
                end else begin
                    case (i_status.key_op)
                        cleb_pkg::K_HOME: o_op = cleb_pkg::DP_HOME;
                        cleb_pkg::K_END:  o_op = cleb_pkg::DP_END;
                        cleb_pkg::K_DEL, cleb_pkg::K_LEFT: begin
                            if (!i_status.cur_at_head) begin
                                o_op    = cleb_pkg::DP_RD_CUR;
                                n_state = cleb_pkg::ST_APPLY;
                            end
                        end
                        cleb_pkg::K_RIGHT: begin
                            if (!i_status.cur_at_tail) begin
                                o_op    = cleb_pkg::DP_RD_CUR;
                                n_state = cleb_pkg::ST_APPLY;
                            end
                        end
                        cleb_pkg::K_INS: begin
                            if (i_status.full) begin
                                o_op = cleb_pkg::DP_OVF;
                            end else begin
                                o_op    = cleb_pkg::DP_RD_CUR;
                                n_state = cleb_pkg::ST_APPLY;
                            end
                        end
                        default: o_op = cleb_pkg::DP_NOP;
                    endcase
                end
            end
            cleb_pkg::ST_APPLY: begin
                n_state = cleb_pkg::ST_IDLE;
                case (i_status.key_op)
                    cleb_pkg::K_DEL:   o_op = cleb_pkg::DP_DEL_WR;
                    cleb_pkg::K_RIGHT: o_op = cleb_pkg::DP_RIGHT;
                    cleb_pkg::K_LEFT:  o_op = cleb_pkg::DP_LEFT;
                    cleb_pkg::K_INS: begin
                        o_op    = cleb_pkg::DP_INS_W1;
                        n_state = cleb_pkg::ST_INS_W2;
                    end
                    default: o_op = cleb_pkg::DP_NOP;
                endcase
            end
            cleb_pkg::ST_INS_W2: begin
                o_op    = cleb_pkg::DP_INS_W2;
                n_state = cleb_pkg::ST_IDLE;
            end
            cleb_pkg::ST_RO_WALK: begin
                if (i_status.out_free) begin
                    o_op = cleb_pkg::DP_RO_STEP;
                    if (i_status.walk_last) begin
                        n_state = cleb_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = cleb_pkg::ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

### design/cleb_dp.sv
// Datapath: key registers, linked list memories, free stack and output register.
`default_nettype none

module cleb_dp #(
    parameter int CAPACITY = cleb_pkg::CAPACITY_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [cleb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [cleb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_command,
    input  wire logic [cleb_pkg::CHAR_W-1:0]     i_key,
    input  wire logic                            i_out_ready,
    output      logic                            o_out_valid,
    output      logic [cleb_pkg::CHAR_W-1:0]     o_char_out,
    output      logic                            o_has_char,
    output      logic                            o_overflowed,
    output      logic                            o_last,
    input  wire cleb_pkg::t_dp_op                i_op,
    output      cleb_pkg::t_dp_status            o_status
);

    localparam int IW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = cleb_pkg::CHAR_W;
    localparam logic [LW-1:0] HEAD    = LW'(CAPACITY);
    localparam logic [LW-1:0] CAP_CNT = LW'(CAPACITY);

    logic [CW-1:0] r_home, n_home, r_end, n_end, r_del, n_del;
    logic [CW-1:0] r_right, n_right, r_left, n_left;
    logic          r_cmd, n_cmd;
    logic [CW-1:0] r_key, n_key;
    logic [LW-1:0] r_head_next, n_head_next, r_tail, n_tail, r_cursor, n_cursor;
    logic [LW-1:0] r_count, n_count, r_fresh, n_fresh, r_top, n_top;
    logic          r_ovf, n_ovf;
    logic [IW-1:0] r_slot, n_slot;
    logic [LW-1:0] r_nxt, n_nxt;
    logic          r_out_valid, n_out_valid;
    logic [CW-1:0] r_out_char, n_out_char;
    logic          r_out_has, n_out_has, r_out_ovf, n_out_ovf, r_out_last, n_out_last;

    logic          cs_we, cs_re;
    logic [IW-1:0] cs_waddr, cs_raddr;
    logic [CW-1:0] cs_wdata, cs_rdata;
    logic          nl_we, nl_re;
    logic [IW-1:0] nl_waddr, nl_raddr;
    logic [LW-1:0] nl_wdata, nl_rdata;
    logic          pl_we, pl_re;
    logic [IW-1:0] pl_waddr, pl_raddr;
    logic [LW-1:0] pl_wdata, pl_rdata;
    logic          fs_we, fs_re;
    logic [IW-1:0] fs_waddr, fs_raddr;
    logic [IW-1:0] fs_wdata, fs_rdata;

    logic          cur_at_head, cur_at_tail, out_free, walk_last;
    logic [IW-1:0] cur_idx, top_idx, ins_slot;
    logic [LW-1:0] ins_nxt, slot_ext;
    cleb_pkg::t_key_op key_op;

    cleb_ram #(.WIDTH(CW), .DEPTH(CAPACITY)) u_char_store (
        .i_clk(i_clk), .i_we(cs_we), .i_waddr(cs_waddr), .i_wdata(cs_wdata),
        .i_re(cs_re), .i_raddr(cs_raddr), .o_rdata(cs_rdata)
    );
    cleb_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_next_link (
        .i_clk(i_clk), .i_we(nl_we), .i_waddr(nl_waddr), .i_wdata(nl_wdata),
        .i_re(nl_re), .i_raddr(nl_raddr), .o_rdata(nl_rdata)
    );
    cleb_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_prev_link (
        .i_clk(i_clk), .i_we(pl_we), .i_waddr(pl_waddr), .i_wdata(pl_wdata),
        .i_re(pl_re), .i_raddr(pl_raddr), .o_rdata(pl_rdata)
    );
    cleb_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_free_stack (
        .i_clk(i_clk), .i_we(fs_we), .i_waddr(fs_waddr), .i_wdata(fs_wdata),
        .i_re(fs_re), .i_raddr(fs_raddr), .o_rdata(fs_rdata)
    );

    // Status decode; key match priority: home, end, delete, right, left.
    always_comb begin
        if (r_key == r_home) begin
            key_op = cleb_pkg::K_HOME;
        end else if (r_key == r_end) begin
            key_op = cleb_pkg::K_END;
        end else if (r_key == r_del) begin
            key_op = cleb_pkg::K_DEL;
        end else if (r_key == r_right) begin
            key_op = cleb_pkg::K_RIGHT;
        end else if (r_key == r_left) begin
            key_op = cleb_pkg::K_LEFT;
        end else begin
            key_op = cleb_pkg::K_INS;
        end
    end

    assign cur_at_head = (r_cursor == HEAD);
    assign cur_at_tail = (r_cursor == r_tail);
    assign out_free    = !r_out_valid || i_out_ready;
    assign walk_last   = (nl_rdata == HEAD);
    assign cur_idx     = cur_at_head ? '0 : r_cursor[IW-1:0];
    assign top_idx     = (r_top == '0) ? '0 : IW'(r_top - LW'(1));
    assign ins_slot    = (r_top != '0) ? fs_rdata : r_fresh[IW-1:0];
    assign ins_nxt     = cur_at_head ? r_head_next : nl_rdata;
    assign slot_ext    = LW'(r_slot);

    assign o_status.key_op      = key_op;
    assign o_status.is_readout  = r_cmd;
    assign o_status.cur_at_head = cur_at_head;
    assign o_status.cur_at_tail = cur_at_tail;
    assign o_status.full        = (r_count == CAP_CNT);
    assign o_status.list_empty  = (r_head_next == HEAD);
    assign o_status.out_free    = out_free;
    assign o_status.walk_last   = walk_last;

    always_comb begin
        n_home = r_home; n_end = r_end; n_del = r_del; n_right = r_right; n_left = r_left;
        n_cmd = r_cmd; n_key = r_key;
        n_head_next = r_head_next; n_tail = r_tail; n_cursor = r_cursor;
        n_count = r_count; n_fresh = r_fresh; n_top = r_top; n_ovf = r_ovf;
        n_slot = r_slot; n_nxt = r_nxt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_char = r_out_char; n_out_has = r_out_has;
        n_out_ovf = r_out_ovf; n_out_last = r_out_last;
        cs_we = 1'b0; cs_waddr = '0; cs_wdata = '0; cs_re = 1'b0; cs_raddr = '0;
        nl_we = 1'b0; nl_waddr = '0; nl_wdata = '0; nl_re = 1'b0; nl_raddr = '0;
        pl_we = 1'b0; pl_waddr = '0; pl_wdata = '0; pl_re = 1'b0; pl_raddr = '0;
        fs_we = 1'b0; fs_waddr = '0; fs_wdata = '0; fs_re = 1'b0; fs_raddr = '0;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                cleb_pkg::CFG_HOME:   n_home  = i_cfg_data;
                cleb_pkg::CFG_END:    n_end   = i_cfg_data;
                cleb_pkg::CFG_DELETE: n_del   = i_cfg_data;
                cleb_pkg::CFG_RIGHT:  n_right = i_cfg_data;
                cleb_pkg::CFG_LEFT:   n_left  = i_cfg_data;
                default: ;
            endcase
        end

        case (i_op)
            cleb_pkg::DP_CAPTURE: begin
                n_cmd = i_command;
                n_key = i_key;
            end
            cleb_pkg::DP_HOME: n_cursor = HEAD;
            cleb_pkg::DP_END:  n_cursor = r_tail;
            cleb_pkg::DP_OVF:  n_ovf    = 1'b1;
            cleb_pkg::DP_RD_CUR: begin
                nl_re = 1'b1; nl_raddr = cur_idx;
                pl_re = 1'b1; pl_raddr = cur_idx;
                fs_re = 1'b1; fs_raddr = top_idx;
            end
            cleb_pkg::DP_RIGHT: n_cursor = cur_at_head ? r_head_next : nl_rdata;
            cleb_pkg::DP_LEFT:  n_cursor = pl_rdata;
            cleb_pkg::DP_DEL_WR: begin
                if (pl_rdata == HEAD) begin
                    n_head_next = nl_rdata;
                end else begin
                    nl_we = 1'b1; nl_waddr = pl_rdata[IW-1:0]; nl_wdata = nl_rdata;
                end
                if (nl_rdata == HEAD) begin
                    n_tail = pl_rdata;
                end else begin
                    pl_we = 1'b1; pl_waddr = nl_rdata[IW-1:0]; pl_wdata = pl_rdata;
                end
                n_cursor = pl_rdata;
                n_count  = r_count - LW'(1);
                fs_we    = 1'b1;
                fs_waddr = r_top[IW-1:0];
                fs_wdata = r_cursor[IW-1:0];
                n_top    = r_top + LW'(1);
            end
            cleb_pkg::DP_INS_W1: begin
                cs_we = 1'b1; cs_waddr = ins_slot; cs_wdata = r_key;
                nl_we = 1'b1; nl_waddr = ins_slot; nl_wdata = ins_nxt;
                pl_we = 1'b1; pl_waddr = ins_slot; pl_wdata = r_cursor;
                n_slot = ins_slot;
                n_nxt  = ins_nxt;
                if (r_top != '0) begin
                    n_top = r_top - LW'(1);
                end else begin
                    n_fresh = r_fresh + LW'(1);
                end
            end
            cleb_pkg::DP_INS_W2: begin
                if (r_nxt == HEAD) begin
                    n_tail = slot_ext;
                end else begin
                    pl_we = 1'b1; pl_waddr = r_nxt[IW-1:0]; pl_wdata = slot_ext;
                end
                if (cur_at_head) begin
                    n_head_next = slot_ext;
                end else begin
                    nl_we = 1'b1; nl_waddr = r_cursor[IW-1:0]; nl_wdata = slot_ext;
                end
                n_cursor = slot_ext;
                n_count  = r_count + LW'(1);
            end
            cleb_pkg::DP_RO_START: begin
                nl_re = 1'b1; nl_raddr = r_head_next[IW-1:0];
                cs_re = 1'b1; cs_raddr = r_head_next[IW-1:0];
            end
            cleb_pkg::DP_RO_STEP, cleb_pkg::DP_RO_EMPTY: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_ovf   = r_ovf;
                    if (i_op == cleb_pkg::DP_RO_STEP) begin
                        n_out_char = cs_rdata;
                        n_out_has  = 1'b1;
                        n_out_last = walk_last;
                    end else begin
                        n_out_char = '0;
                        n_out_has  = 1'b0;
                        n_out_last = 1'b1;
                    end
                    if (i_op == cleb_pkg::DP_RO_EMPTY || walk_last) begin
                        n_head_next = HEAD;
                        n_tail      = HEAD;
                        n_cursor    = HEAD;
                        n_count     = '0;
                        n_fresh     = '0;
                        n_top       = '0;
                        n_ovf       = 1'b0;
                    end else begin
                        nl_re = 1'b1; nl_raddr = nl_rdata[IW-1:0];
                        cs_re = 1'b1; cs_raddr = nl_rdata[IW-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_home      <= cleb_pkg::HOME_RST;
            r_end       <= cleb_pkg::END_RST;
            r_del       <= cleb_pkg::DELETE_RST;
            r_right     <= cleb_pkg::RIGHT_RST;
            r_left      <= cleb_pkg::LEFT_RST;
            r_head_next <= HEAD;
            r_tail      <= HEAD;
            r_cursor    <= HEAD;
            r_count     <= '0;
            r_fresh     <= '0;
            r_top       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_home      <= n_home;
            r_end       <= n_end;
            r_del       <= n_del;
            r_right     <= n_right;
            r_left      <= n_left;
            r_head_next <= n_head_next;
            r_tail      <= n_tail;
            r_cursor    <= n_cursor;
            r_count     <= n_count;
            r_fresh     <= n_fresh;
            r_top       <= n_top;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_slot     <= n_slot;
        r_nxt      <= n_nxt;
        r_out_char <= n_out_char;
        r_out_has  <= n_out_has;
        r_out_ovf  <= n_out_ovf;
        r_out_last <= n_out_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_char_out   = r_out_char;
    assign o_has_char   = r_out_has;
    assign o_overflowed = r_out_ovf;
    assign o_last       = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("character count above capacity");

    // slot is taken in the cycle before the count moves during an insert
    a_slot_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op != cleb_pkg::DP_INS_W2) |-> ((r_count + r_top) == r_fresh))
        else $error("slot accounting out of balance");

    a_empty_links: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_count == '0) == (r_head_next == HEAD)) && ((r_count == '0) == (r_tail == HEAD)))
        else $error("empty list and sentinel links disagree");

    a_readout_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == cleb_pkg::DP_RO_STEP && out_free && walk_last) |=>
        (r_count == '0 && r_cursor == HEAD && r_out_valid && r_out_last))
        else $error("readout end did not clear the buffer");

endmodule

`default_nettype wire

### design/cursor_line_edit_buffer.sv
// Top level of the cursor line edit buffer: controller plus datapath.
// A bounded line editor holding up to CAPACITY characters in a doubly linked
// list with a cursor. A keystroke transaction passes through the capture and
// dispatch states; home/end, moves or deletes that hit a list end and an
// insert into a full buffer end there. Left, right and delete add an apply
// state, and an insert adds apply and a second write state, since the
// registered-read link memories are read in dispatch before the links are
// rewritten. A readout transaction returns one output transaction per
// character (a single empty transaction when the buffer is empty), with last
// set on the final one, then clears the buffer and the overflow flag. Output
// stalls pause the walk. No clearing pass runs after reset. The user sets key
// codes through the write port while idle; the block does not enforce this.
`default_nettype none

module cursor_line_edit_buffer #(
    parameter int CAPACITY = cleb_pkg::CAPACITY_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [cleb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [cleb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    cleb_in_if.sink                              i_in,
    cleb_out_if.source                           o_out
);

    cleb_pkg::t_dp_op     op;
    cleb_pkg::t_dp_status status;
    logic                 in_ready;

    assign i_in.ready = in_ready;

    cleb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_op       (op)
    );

    cleb_dp #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_command    (i_in.command),
        .i_key        (i_in.key),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_char_out   (o_out.char_out),
        .o_has_char   (o_out.has_char),
        .o_overflowed (o_out.overflowed),
        .o_last       (o_out.last),
        .i_op         (op),
        .o_status     (status)
    );

endmodule

`default_nettype wire
